/* design/brf_pkg.sv */
`timescale 1ns / 1ps
// brf_pkg: shared types, codes and saturating fixed-point helpers for the
// Brent root finder. No dependencies.
package brf_pkg;

	localparam int W = 64;
	localparam int FRAC_BITS_DEF = 32;
	localparam int TOL_W = 33;
	localparam int ITER_W = 8;
	localparam int ADDR_W = 5;

	localparam logic signed [W-1:0] S_MAX = {1'b0, {(W-1){1'b1}}};
	localparam logic signed [W-1:0] S_MIN = {1'b1, {(W-1){1'b0}}};

	// result status codes
	localparam logic [1:0] ST_EVAL  = 2'd0;
	localparam logic [1:0] ST_ROOT  = 2'd1;
	localparam logic [1:0] ST_NOBR  = 2'd2;
	localparam logic [1:0] ST_LIMIT = 2'd3;

	// register indexes
	localparam logic [1:0] REG_LOW  = 2'd0;
	localparam logic [1:0] REG_HIGH = 2'd1;
	localparam logic [1:0] REG_TOL  = 2'd2;
	localparam logic [1:0] REG_MAX  = 2'd3;

	typedef struct packed {
		logic signed [W-1:0] low;
		logic signed [W-1:0] high;
		logic [TOL_W-1:0]    tol;
		logic [ITER_W-1:0]   max_iter;
	} cfg_t;

	typedef struct packed {
		logic                start;
		logic                is_div;
		logic signed [W-1:0] a;
		logic signed [W-1:0] b;
	} md_req_t;

	typedef struct packed {
		logic                done;
		logic signed [W-1:0] result;
	} md_rsp_t;

	function automatic logic [W-1:0] mag(input logic signed [W-1:0] x);
		mag = x[W-1] ? (~x + 1'b1) : x;
	endfunction

	function automatic logic signed [W-1:0] from_mag(input logic [W-1:0] m,
			input logic neg, input logic ovf);
		if (neg)
			from_mag = (ovf || m[W-1]) ? S_MIN : -$signed(m);
		else
			from_mag = (ovf || m[W-1]) ? S_MAX : $signed(m);
	endfunction

	function automatic logic signed [W-1:0] sadd(input logic signed [W-1:0] a,
			input logic signed [W-1:0] b);
		logic signed [W:0] s;
		s = {a[W-1], a} + {b[W-1], b};
		if (s[W] != s[W-1]) sadd = s[W] ? S_MIN : S_MAX;
		else sadd = s[W-1:0];
	endfunction

	function automatic logic signed [W-1:0] ssub(input logic signed [W-1:0] a,
			input logic signed [W-1:0] b);
		logic signed [W:0] s;
		s = {a[W-1], a} - {b[W-1], b};
		if (s[W] != s[W-1]) ssub = s[W] ? S_MIN : S_MAX;
		else ssub = s[W-1:0];
	endfunction

	function automatic logic signed [W-1:0] sabs(input logic signed [W-1:0] x);
		if (x == S_MIN) sabs = S_MAX;
		else sabs = x[W-1] ? -x : x;
	endfunction

	// trunc((c - b) / 2) over the full 65-bit difference
	function automatic logic signed [W-1:0] half_diff(input logic signed [W-1:0] c,
			input logic signed [W-1:0] b);
		logic [W:0] d;
		logic [W:0] m;
		d = {c[W-1], c} - {b[W-1], b};
		if (d[W]) begin
			m = (~d + 1'b1) >> 1;
			half_diff = -$signed(m[W-1:0]);
		end else begin
			m = d >> 1;
			half_diff = m[W-1:0];
		end
	endfunction

	function automatic logic same_sign(input logic signed [W-1:0] x,
			input logic signed [W-1:0] y);
		same_sign = (x != '0) && (y != '0) && (x[W-1] == y[W-1]);
	endfunction

endpackage

/* design/brf_if.sv */
`timescale 1ns / 1ps
// brf_if: valid/ready channels for function values in and results out.
// No dependencies.
interface brf_in_if;
	logic        valid;
	logic        ready;
	logic [63:0] f_value;
	modport source(output valid, output f_value, input ready);
	modport sink(input valid, input f_value, output ready);
endinterface

interface brf_out_if;
	logic        valid;
	logic        ready;
	logic [63:0] point;
	logic [1:0]  status;
	logic        done_res;
	modport source(output valid, output point, output status, output done_res, input ready);
	modport sink(input valid, input point, input status, input done_res, output ready);
endinterface

/* design/brf_cfg.sv */
`timescale 1ns / 1ps
// brf_cfg: APB register bank (bracket, tolerance, iteration limit).
// Depends on brf_pkg.
module brf_cfg (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [brf_pkg::ADDR_W-1:0] paddr,
	input  logic [63:0]                pwdata,
	output logic [63:0]                prdata,
	output logic                       pready,
	output brf_pkg::cfg_t              cfg
);
	import brf_pkg::*;

	cfg_t       cfg_q;
	logic [1:0] idx;

	assign idx    = paddr[4:3];
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.low      <= '0;
			cfg_q.high     <= 64'sh1_0000_0000;
			cfg_q.tol      <= TOL_W'(1);
			cfg_q.max_iter <= ITER_W'(100);
		end else if (psel && penable && pwrite) begin
			case (idx)
				REG_LOW:  cfg_q.low      <= pwdata;
				REG_HIGH: cfg_q.high     <= pwdata;
				REG_TOL:  cfg_q.tol      <= pwdata[TOL_W-1:0];
				REG_MAX:  cfg_q.max_iter <= pwdata[ITER_W-1:0];
				default:  cfg_q.low      <= cfg_q.low;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_LOW:  prdata = cfg_q.low;
			REG_HIGH: prdata = cfg_q.high;
			REG_TOL:  prdata = {{(64-TOL_W){1'b0}}, cfg_q.tol};
			REG_MAX:  prdata = {{(64-ITER_W){1'b0}}, cfg_q.max_iter};
			default:  prdata = '0;
		endcase
	end
endmodule

/* design/brf_muldiv.sv */
`timescale 1ns / 1ps
// brf_muldiv: bit-serial fixed-point multiply (shift-add, one bit a cycle)
// and restoring divide (one quotient bit a cycle). Depends on brf_pkg.
module brf_muldiv #(
	parameter int FRAC_BITS = brf_pkg::FRAC_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  brf_pkg::md_req_t  req,
	output brf_pkg::md_rsp_t  rsp
);
	import brf_pkg::*;

	localparam int DIV_STEPS = W + FRAC_BITS;
	localparam int CW = $clog2(DIV_STEPS + 1);

	logic            busy_q, div_q, neg_q, done_q, ovf_q;
	logic [CW-1:0]   cnt_q;
	logic [2*W-1:0]  prod_q;
	logic [W-1:0]    opb_q, rem_q, num_q, quo_q;
	logic signed [W-1:0] res_q;

	logic [W-1:0]    ma, mb;
	logic [W:0]      msum, rem2, rdiff;
	logic            ge, last;
	logic [W-1:0]    fin_m;
	logic            fin_ovf;

	assign ma = mag(req.a);
	assign mb = mag(req.b);

	assign msum  = {1'b0, prod_q[2*W-1:W]} + (prod_q[0] ? {1'b0, opb_q} : '0);
	assign rem2  = {rem_q, num_q[W-1]};
	assign rdiff = rem2 - {1'b0, opb_q};
	assign ge    = ~rdiff[W];
	assign last  = div_q ? (cnt_q == CW'(DIV_STEPS)) : (cnt_q == CW'(W));

	assign fin_m   = div_q ? quo_q : prod_q[FRAC_BITS+W-1:FRAC_BITS];
	assign fin_ovf = div_q ? ovf_q : (|prod_q[2*W-1:W+FRAC_BITS]);

	assign rsp.done   = done_q;
	assign rsp.result = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				cnt_q <= '0;
				if (req.is_div && mb == '0) begin
					// zero divisor: saturate toward the dividend sign, 0/0 is 0
					done_q <= 1'b1;
				end else begin
					busy_q <= 1'b1;
				end
			end else if (busy_q) begin
				if (last) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			div_q  <= req.is_div;
			neg_q  <= req.a[W-1] ^ req.b[W-1];
			opb_q  <= mb;
			prod_q <= {{W{1'b0}}, ma};
			num_q  <= ma;
			rem_q  <= '0;
			quo_q  <= '0;
			ovf_q  <= 1'b0;
			if (req.is_div && mb == '0)
				res_q <= (ma == '0) ? '0 : (req.a[W-1] ? S_MIN : S_MAX);
		end else if (busy_q) begin
			if (last) begin
				res_q <= from_mag(fin_m, neg_q, fin_ovf);
			end else if (div_q) begin
				rem_q <= ge ? rdiff[W-1:0] : rem2[W-1:0];
				num_q <= {num_q[W-2:0], 1'b0};
				quo_q <= {quo_q[W-2:0], ge};
				ovf_q <= ovf_q | quo_q[W-1];
			end else begin
				prod_q <= {msum, prod_q[W-1:1]};
			end
		end
	end
endmodule

/* design/brent_root_finder.sv */
`timescale 1ns / 1ps
// brent_root_finder: Brent-Dekker root search steering an outside function
// evaluator. Depends on brf_pkg, brf_if, brf_cfg, brf_muldiv.
//
//  channel  dir  payload                       handshake
//  in_ch    in   f_value[63:0]                 valid/ready
//  out_ch   out  point[63:0] status[1:0] done  valid/ready
//  apb      in   paddr[4:0] pwdata/prdata[63:0] psel/penable, pready=1
//
// The low-end item goes from idle straight to the output hand-off; so does
// the high-end item unless it starts the search. A bisecting search step only
// runs the sequencer states; an interpolation step also runs 5 to 13 serial
// operations on the one shared multiply/divide unit.
// Reset clears the sequencer, phase and output valid; no clearing pass.
// in_ch.ready is high only while the sequencer is idle; a finished result
// waits in its own stage until the output register is free.
module brent_root_finder #(
	parameter int FRAC_BITS = brf_pkg::FRAC_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [brf_pkg::ADDR_W-1:0] paddr,
	input  logic [63:0]                pwdata,
	output logic [63:0]                prdata,
	output logic                       pready,
	brf_in_if.sink                     in_ch,
	brf_out_if.source                  out_ch
);
	import brf_pkg::*;

	localparam logic signed [W-1:0] ONE = W'(1) << FRAC_BITS;

	typedef enum logic [10:0] {
		S_IDLE  = 11'b00000000001,
		S_IT0   = 11'b00000000010,  // re-bracket if b and c agree in sign
		S_IT1   = 11'b00000000100,  // keep b as the best point
		S_IT2   = 11'b00000001000,  // midpoint offset
		S_IT3   = 11'b00000010000,  // convergence and method choice
		S_ISSUE = 11'b00000100000,
		S_WAIT  = 11'b00001000000,
		S_PQ    = 11'b00010000000,
		S_CMP   = 11'b00100000000,
		S_UPD   = 11'b01000000000,
		S_EMIT  = 11'b10000000000
	} state_t;

	typedef enum logic [3:0] {
		OP_S, OP_P0, OP_QQ, OP_R, OP_T1A, OP_T1, OP_T2, OP_P1,
		OP_QA, OP_Q1, OP_M1A, OP_M1B, OP_M2, OP_D
	} op_t;

	typedef enum logic [1:0] {
		PH_LOW  = 2'd0,
		PH_HIGH = 2'd1,
		PH_NEW  = 2'd2
	} phase_t;

	cfg_t    cfg;
	md_req_t md_req;
	md_rsp_t md_rsp;

	state_t st_q;
	op_t    op_q;
	phase_t phase_q;
	logic [ITER_W-1:0] cnt_q;

	// search state
	logic signed [W-1:0] pa_q, pb_q, pc_q, va_q, vb_q, vc_q, d_q, e_q;
	// step temporaries
	logic signed [W-1:0] xm_q, s_q, qq_q, r_q, tmp_q, t1_q, t2_q, p_q, qv_q;
	logic signed [W-1:0] m1a_q, m1b_q, m2_q;

	logic signed [W-1:0] res_point_q;
	logic [1:0]          res_status_q;
	logic                out_valid_q;
	logic signed [W-1:0] out_point_q;
	logic [1:0]          out_status_q;

	logic signed [W-1:0] f, tol_s, xm2, m1, mmin, pnew, tstep;

	brf_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	brf_muldiv #(.FRAC_BITS(FRAC_BITS)) u_md (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (md_req),
		.rsp    (md_rsp)
	);

	assign f     = in_ch.f_value;
	assign tol_s = {{(W-TOL_W){1'b0}}, cfg.tol};
	assign xm2   = sadd(xm_q, xm_q);
	assign m1    = ssub(m1a_q, sabs(m1b_q));
	assign mmin  = (m1 < m2_q) ? m1 : m2_q;
	assign tstep = (mag(d_q) > {{(W-TOL_W){1'b0}}, cfg.tol}) ? d_q :
	               ((xm_q > 0) ? tol_s : -tol_s);
	assign pnew  = sadd(pb_q, tstep);

	assign in_ch.ready     = (st_q == S_IDLE);
	assign out_ch.valid    = out_valid_q;
	assign out_ch.point    = out_point_q;
	assign out_ch.status   = out_status_q;
	assign out_ch.done_res = (out_status_q != ST_EVAL);

	// operand select for the shared unit
	always_comb begin
		md_req.start  = (st_q == S_ISSUE);
		md_req.is_div = 1'b0;
		md_req.a      = '0;
		md_req.b      = '0;
		case (op_q)
			OP_S:   begin md_req.is_div = 1'b1; md_req.a = vb_q; md_req.b = va_q; end
			OP_P0:  begin md_req.a = xm2; md_req.b = s_q; end
			OP_QQ:  begin md_req.is_div = 1'b1; md_req.a = va_q; md_req.b = vc_q; end
			OP_R:   begin md_req.is_div = 1'b1; md_req.a = vb_q; md_req.b = vc_q; end
			OP_T1A: begin md_req.a = xm2; md_req.b = qq_q; end
			OP_T1:  begin md_req.a = tmp_q; md_req.b = ssub(qq_q, r_q); end
			OP_T2:  begin md_req.a = ssub(pb_q, pa_q); md_req.b = ssub(r_q, ONE); end
			OP_P1:  begin md_req.a = s_q; md_req.b = ssub(t1_q, t2_q); end
			OP_QA:  begin md_req.a = ssub(qq_q, ONE); md_req.b = ssub(r_q, ONE); end
			OP_Q1:  begin md_req.a = tmp_q; md_req.b = ssub(s_q, ONE); end
			OP_M1A: begin md_req.a = sadd(xm2, xm_q); md_req.b = qv_q; end
			OP_M1B: begin md_req.a = tol_s; md_req.b = qv_q; end
			OP_M2:  begin md_req.a = e_q; md_req.b = qv_q; end
			OP_D:   begin md_req.is_div = 1'b1; md_req.a = p_q; md_req.b = qv_q; end
			default: md_req.is_div = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= S_IDLE;
			phase_q     <= PH_LOW;
			op_q        <= OP_S;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// output register loads from the pending stage or drains
			if (st_q == S_EMIT && (!out_valid_q || out_ch.ready))
				out_valid_q <= 1'b1;
			else if (out_valid_q && out_ch.ready)
				out_valid_q <= 1'b0;
			case (st_q)
				S_IDLE: begin
					if (in_ch.valid) begin
						case (phase_q)
							PH_HIGH: begin
								if (same_sign(va_q, f)) begin
									phase_q <= PH_LOW;
									st_q    <= S_EMIT;
								end else if (cfg.max_iter == '0) begin
									phase_q <= PH_LOW;
									st_q    <= S_EMIT;
								end else begin
									cnt_q   <= ITER_W'(1);
									phase_q <= PH_NEW;
									st_q    <= S_IT0;
								end
							end
							PH_NEW: begin
								if (cnt_q >= cfg.max_iter) begin
									phase_q <= PH_LOW;
									st_q    <= S_EMIT;
								end else begin
									cnt_q <= cnt_q + 1'b1;
									st_q  <= S_IT0;
								end
							end
							default: begin
								// low-end value, also the unused phase code
								phase_q <= PH_HIGH;
								st_q    <= S_EMIT;
							end
						endcase
					end
				end
				S_IT0: st_q <= S_IT1;
				S_IT1: st_q <= S_IT2;
				S_IT2: st_q <= S_IT3;
				S_IT3: begin
					if (mag(xm_q) <= {{(W-TOL_W){1'b0}}, cfg.tol} || vb_q == '0) begin
						phase_q <= PH_LOW;
						st_q    <= S_EMIT;
					end else if (mag(e_q) >= {{(W-TOL_W){1'b0}}, cfg.tol} &&
					             mag(va_q) > mag(vb_q)) begin
						op_q <= OP_S;
						st_q <= S_ISSUE;
					end else begin
						st_q <= S_UPD;
					end
				end
				S_ISSUE: st_q <= S_WAIT;
				S_WAIT: begin
					if (md_rsp.done) begin
						st_q <= S_ISSUE;
						case (op_q)
							OP_S:   op_q <= (pa_q == pc_q) ? OP_P0 : OP_QQ;
							OP_P0:  st_q <= S_PQ;
							OP_QQ:  op_q <= OP_R;
							OP_R:   op_q <= OP_T1A;
							OP_T1A: op_q <= OP_T1;
							OP_T1:  op_q <= OP_T2;
							OP_T2:  op_q <= OP_P1;
							OP_P1:  op_q <= OP_QA;
							OP_QA:  op_q <= OP_Q1;
							OP_Q1:  st_q <= S_PQ;
							OP_M1A: op_q <= OP_M1B;
							OP_M1B: op_q <= OP_M2;
							OP_M2:  st_q <= S_CMP;
							default: st_q <= S_UPD;
						endcase
					end
				end
				S_PQ: begin
					op_q <= OP_M1A;
					st_q <= S_ISSUE;
				end
				S_CMP: begin
					if (sadd(p_q, p_q) < mmin) begin
						op_q <= OP_D;
						st_q <= S_ISSUE;
					end else begin
						st_q <= S_UPD;
					end
				end
				S_UPD: st_q <= S_EMIT;
				S_EMIT: begin
					if (!out_valid_q || out_ch.ready)
						st_q <= S_IDLE;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pa_q <= '0; pb_q <= '0; pc_q <= '0;
			va_q <= '0; vb_q <= '0; vc_q <= '0;
			d_q  <= '0; e_q  <= '0;
		end else begin
			case (st_q)
				S_IDLE: begin
					if (in_ch.valid) begin
						case (phase_q)
							PH_HIGH: begin
								pb_q <= cfg.high;
								pc_q <= cfg.high;
								vb_q <= f;
								if (!same_sign(va_q, f))
									vc_q <= f;
							end
							PH_NEW: vb_q <= f;
							default: begin
								pa_q <= cfg.low;
								va_q <= f;
							end
						endcase
					end
				end
				S_IT0: begin
					if (same_sign(vb_q, vc_q)) begin
						pc_q <= pa_q;
						vc_q <= va_q;
						d_q  <= ssub(pb_q, pa_q);
						e_q  <= ssub(pb_q, pa_q);
					end
				end
				S_IT1: begin
					if (mag(vc_q) < mag(vb_q)) begin
						pa_q <= pb_q; pb_q <= pc_q; pc_q <= pb_q;
						va_q <= vb_q; vb_q <= vc_q; vc_q <= vb_q;
					end
				end
				S_IT3: begin
					if (!(mag(xm_q) <= {{(W-TOL_W){1'b0}}, cfg.tol} || vb_q == '0) &&
					    !(mag(e_q) >= {{(W-TOL_W){1'b0}}, cfg.tol} &&
					      mag(va_q) > mag(vb_q))) begin
						d_q <= xm_q;
						e_q <= xm_q;
					end
				end
				S_WAIT: begin
					if (md_rsp.done && op_q == OP_D)
						d_q <= md_rsp.result;
				end
				S_CMP: begin
					if (sadd(p_q, p_q) < mmin) begin
						e_q <= d_q;
					end else begin
						d_q <= xm_q;
						e_q <= xm_q;
					end
				end
				S_UPD: begin
					pa_q <= pb_q;
					va_q <= vb_q;
					pb_q <= pnew;
				end
				default: pa_q <= pa_q;
			endcase
		end
	end

	// step temporaries and the pending result, no reset needed
	always_ff @(posedge clk) begin
		case (st_q)
			S_IDLE: begin
				case (phase_q)
					PH_HIGH: begin
						res_point_q  <= cfg.high;
						res_status_q <= same_sign(va_q, f) ? ST_NOBR : ST_LIMIT;
					end
					PH_NEW: begin
						res_point_q  <= pb_q;
						res_status_q <= ST_LIMIT;
					end
					default: begin
						res_point_q  <= cfg.high;
						res_status_q <= ST_EVAL;
					end
				endcase
			end
			S_IT2: xm_q <= half_diff(pc_q, pb_q);
			S_IT3: begin
				res_point_q  <= pb_q;
				res_status_q <= ST_ROOT;
			end
			S_WAIT: begin
				if (md_rsp.done) begin
					case (op_q)
						OP_S:   s_q   <= md_rsp.result;
						OP_P0:  begin p_q <= md_rsp.result; qv_q <= ssub(ONE, s_q); end
						OP_QQ:  qq_q  <= md_rsp.result;
						OP_R:   r_q   <= md_rsp.result;
						OP_T1A: tmp_q <= md_rsp.result;
						OP_T1:  t1_q  <= md_rsp.result;
						OP_T2:  t2_q  <= md_rsp.result;
						OP_P1:  p_q   <= md_rsp.result;
						OP_QA:  tmp_q <= md_rsp.result;
						OP_Q1:  qv_q  <= md_rsp.result;
						OP_M1A: m1a_q <= md_rsp.result;
						OP_M1B: m1b_q <= md_rsp.result;
						OP_M2:  m2_q  <= sabs(md_rsp.result);
						default: s_q  <= s_q;
					endcase
				end
			end
			S_PQ: begin
				// p > 0 flips q; p is then taken as magnitude
				if (p_q > 0)
					qv_q <= (qv_q == S_MIN) ? S_MAX : -qv_q;
				p_q <= sabs(p_q);
			end
			S_UPD: begin
				res_point_q  <= pnew;
				res_status_q <= ST_EVAL;
			end
			S_EMIT: begin
				if (!out_valid_q || out_ch.ready) begin
					out_point_q  <= res_point_q;
					out_status_q <= res_status_q;
				end
			end
			default: xm_q <= xm_q;
		endcase
	end
endmodule

/* bench/testbench.sv */
`timescale 1ns / 1ps
// testbench: closed-loop check of brent_root_finder. The bench plays the
// function evaluator and predicts every result. Depends on brf_pkg, brf_if, brent_root_finder.
module testbench;

	import brf_pkg::*;

	localparam int FB = FRAC_BITS_DEF;
	localparam int N_ITEMS = 1650;

	typedef struct {
		logic signed [63:0] point;
		logic [1:0]         status;
		logic               done;
	} search_res_t;

	// Search-state predictor plus the queue of results still owed by the block.
	class brent_scoreboard;
		logic signed [63:0] cfg_low, cfg_high;
		logic [32:0]        cfg_tol;
		logic [7:0]         cfg_max;
		logic signed [63:0] pa, pb, pc, va, vb, vc, d_now, d_prev;
		logic [7:0]         iter_cnt;
		logic [1:0]         phase;
		search_res_t        owed[$];
		int                 fails;
		int                 checked;
		int                 ends[4];

		function new();
			cfg_low = 0; cfg_high = 64'sh1_0000_0000; cfg_tol = 1; cfg_max = 100;
			pa = 0; pb = 0; pc = 0; va = 0; vb = 0; vc = 0;
			d_now = 0; d_prev = 0; iter_cnt = 0; phase = 0;
			fails = 0; checked = 0;
			foreach (ends[i]) ends[i] = 0;
		endfunction

		static function logic [63:0] umag(logic signed [63:0] x);
			logic [63:0] u;
			u = x;
			return x[63] ? (~u + 64'd1) : u;
		endfunction

		static function logic signed [63:0] from_m(logic [63:0] m, logic neg, logic ovf);
			if (neg) return (ovf || m[63]) ? S_MIN : -$signed(m);
			return (ovf || m[63]) ? S_MAX : $signed(m);
		endfunction

		static function logic signed [63:0] s_add(logic signed [63:0] a, logic signed [63:0] b);
			logic signed [64:0] s;
			s = {a[63], a} + {b[63], b};
			if (s[64] != s[63]) return s[64] ? S_MIN : S_MAX;
			return s[63:0];
		endfunction

		static function logic signed [63:0] s_sub(logic signed [63:0] a, logic signed [63:0] b);
			logic signed [64:0] s;
			s = {a[63], a} - {b[63], b};
			if (s[64] != s[63]) return s[64] ? S_MIN : S_MAX;
			return s[63:0];
		endfunction

		static function logic signed [63:0] s_abs(logic signed [63:0] x);
			if (x == S_MIN) return S_MAX;
			return x[63] ? -x : x;
		endfunction

		static function logic signed [63:0] fx_mul(logic signed [63:0] x, logic signed [63:0] y);
			logic [127:0] prod;
			prod = {64'd0, umag(x)} * {64'd0, umag(y)};
			return from_m(prod[FB+63:FB], x[63] != y[63], |(prod >> (64 + FB)));
		endfunction

		static function logic signed [63:0] fx_div(logic signed [63:0] x, logic signed [63:0] y);
			logic [127:0] num, quo;
			logic [63:0]  m, den;
			m = umag(x);
			den = umag(y);
			if (den == 0) begin
				if (m == 0) return 0;
				return x[63] ? S_MIN : S_MAX;
			end
			num = {64'd0, m} << FB;
			quo = num / {64'd0, den};
			return from_m(quo[63:0], x[63] != y[63], |quo[127:64]);
		endfunction

		static function logic signed [63:0] halve_gap(logic signed [63:0] c, logic signed [63:0] b);
			logic signed [64:0] d, h;
			d = {c[63], c} - {b[63], b};
			if (d < 0) begin
				h = (-d) >>> 1;
				return -h[63:0];
			end
			h = d >>> 1;
			return h[63:0];
		endfunction

		static function logic same_sgn(logic signed [63:0] x, logic signed [63:0] y);
			return (x > 0 && y > 0) || (x < 0 && y < 0);
		endfunction

		function void write_reg(logic [1:0] idx, logic [63:0] val);
			case (idx)
				REG_LOW:  cfg_low = val;
				REG_HIGH: cfg_high = val;
				REG_TOL:  cfg_tol = val[32:0];
				default:  cfg_max = val[7:0];
			endcase
		endfunction

		function search_res_t finish(logic signed [63:0] p, logic [1:0] st);
			search_res_t r;
			r.point = p;
			r.status = st;
			r.done = (st != ST_EVAL);
			if (r.done) phase = 0;
			return r;
		endfunction

		// One Brent step: interpolate when it is safe, else bisect.
		function search_res_t brent_step();
			logic signed [63:0] one, tol, xm, xm2, s, p, q, m1, m2, qq, r, t1, t2, t;
			one = 64'sh1 << FB;
			tol = {31'd0, cfg_tol};
			if (same_sgn(vb, vc)) begin
				pc = pa; vc = va;
				d_now = s_sub(pb, pa); d_prev = d_now;
			end
			if (umag(vc) < umag(vb)) begin
				pa = pb; pb = pc; pc = pa;
				va = vb; vb = vc; vc = va;
			end
			xm = halve_gap(pc, pb);
			if (umag(xm) <= {31'd0, cfg_tol} || vb == 0) return finish(pb, ST_ROOT);
			if (umag(d_prev) >= {31'd0, cfg_tol} && umag(va) > umag(vb)) begin
				s = fx_div(vb, va);
				xm2 = s_add(xm, xm);
				if (pa == pc) begin
					p = fx_mul(xm2, s);
					q = s_sub(one, s);
				end else begin
					qq = fx_div(va, vc);
					r = fx_div(vb, vc);
					t1 = fx_mul(fx_mul(xm2, qq), s_sub(qq, r));
					t2 = fx_mul(s_sub(pb, pa), s_sub(r, one));
					p = fx_mul(s, s_sub(t1, t2));
					q = fx_mul(fx_mul(s_sub(qq, one), s_sub(r, one)), s_sub(s, one));
				end
				if (p > 0) q = (q == S_MIN) ? S_MAX : -q;
				p = s_abs(p);
				m1 = s_sub(fx_mul(s_add(s_add(xm, xm), xm), q), s_abs(fx_mul(tol, q)));
				m2 = s_abs(fx_mul(d_prev, q));
				if (s_add(p, p) < ((m1 < m2) ? m1 : m2)) begin
					d_prev = d_now;
					d_now = fx_div(p, q);
				end else begin
					d_now = xm; d_prev = xm;
				end
			end else begin
				d_now = xm; d_prev = xm;
			end
			pa = pb;
			va = vb;
			if (umag(d_now) > {31'd0, cfg_tol}) t = d_now;
			else t = (xm > 0) ? tol : -tol;
			pb = s_add(pb, t);
			return finish(pb, ST_EVAL);
		endfunction

		// Accepted function value: advance the search and queue its result.
		function search_res_t note_value(logic signed [63:0] f);
			search_res_t r;
			if (phase == 1) begin
				pb = cfg_high; pc = cfg_high; vb = f;
				if (same_sgn(va, vb)) r = finish(pb, ST_NOBR);
				else begin
					vc = vb;
					if (cfg_max == 0) r = finish(pb, ST_LIMIT);
					else begin
						iter_cnt = 1; phase = 2;
						r = brent_step();
					end
				end
			end else if (phase == 2) begin
				vb = f;
				if (iter_cnt >= cfg_max) r = finish(pb, ST_LIMIT);
				else begin
					iter_cnt = iter_cnt + 8'd1;
					r = brent_step();
				end
			end else begin
				pa = cfg_low; va = f; phase = 1;
				r = finish(cfg_high, ST_EVAL);
			end
			owed.push_back(r);
			return r;
		endfunction

		function void check_result(logic [63:0] p, logic [1:0] st, logic dn);
			search_res_t e;
			checked++;
			if (owed.size() == 0) begin
				$error("result with nothing owed: point %h status %0d", p, st);
				fails++;
				return;
			end
			e = owed.pop_front();
			ends[e.status]++;
			if (p !== e.point) begin
				$error("point: expected %h actual %h", e.point, p); fails++;
			end
			if (st !== e.status) begin
				$error("status: expected %0d actual %0d", e.status, st); fails++;
			end
			if (dn !== e.done) begin
				$error("done_res: expected %0d actual %0d", e.done, dn); fails++;
			end
		endfunction

		function int pending();
			return owed.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel, penable, pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [63:0] pwdata, prdata;
	logic pready;

	brf_in_if  in_ch();
	brf_out_if out_ch();

	brent_root_finder u_dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_ch(in_ch), .out_ch(out_ch)
	);

	brent_scoreboard sb = new();
	int items_sent = 0;
	int searches = 0;
	bit tx_calm = 1'b0;

	// search target: f(x) = slope * (x - root), or slope * (x - root)^3
	logic signed [63:0] root, slope;

	always #6 clk = ~clk;

	initial begin
		#240_000_000;
		$display("FAIL");
		$finish;
	end

	// setup then access phase; the register takes pwdata on the access edge
	task automatic reg_write(logic [1:0] idx, logic [63:0] val);
		@(posedge clk);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= ADDR_W'(idx) << 3; pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		sb.write_reg(idx, val);
	endtask

	// stop offering items, then wait until every owed result is out
	task automatic wait_idle();
		in_ch.valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic set_config(logic signed [63:0] lo, logic signed [63:0] hi,
			logic [32:0] tol, logic [7:0] mx);
		wait_idle();
		reg_write(REG_LOW, lo);
		reg_write(REG_HIGH, hi);
		reg_write(REG_TOL, {31'd0, tol});
		reg_write(REG_MAX, {56'd0, mx});
	endtask

	function automatic int gap_len();
		if (tx_calm || $urandom_range(0, 3) != 0) return 0;
		return ($urandom_range(0, 9) == 0) ? $urandom_range(15, 90) : $urandom_range(1, 3);
	endfunction

	// offer one function value; valid stays up across back-to-back items
	task automatic send_value(logic signed [63:0] f, output search_res_t r);
		int g;
		g = gap_len();
		if (g > 0) begin
			in_ch.valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.f_value <= f;
		do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
		r = sb.note_value(f);
		items_sent++;
		if ($urandom_range(0, 99) < 3) tx_calm = ~tx_calm;
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic logic signed [63:0] eval_at(int kind, logic signed [63:0] x);
		logic signed [63:0] d;
		d = brent_scoreboard::s_sub(x, root);
		if (kind == 3 || (kind == 2 && $urandom_range(0, 7) == 0)) return rand64();
		if (kind == 1)
			return brent_scoreboard::fx_mul(brent_scoreboard::fx_mul(
				brent_scoreboard::fx_mul(d, d), d), slope);
		return brent_scoreboard::fx_mul(d, slope);
	endfunction

	// play the evaluator until the block reports a final status
	task automatic run_search(int kind);
		search_res_t r;
		logic signed [63:0] x;
		x = sb.cfg_low;
		searches++;
		do begin
			send_value(eval_at(kind, x), r);
			x = r.point;
		end while (!r.done);
	endtask

	task automatic random_config();
		logic signed [63:0] lo, hi, sa, sb_span;
		logic [32:0] tol;
		logic [7:0] mx;
		root = $signed({24'd0, 8'($urandom), $urandom}) - 64'sh80_0000_0000;
		sa = 64'($urandom_range(1, 65535)) << $urandom_range(8, 26);
		sb_span = 64'($urandom_range(1, 65535)) << $urandom_range(8, 26);
		lo = brent_scoreboard::s_sub(root, sa);
		hi = brent_scoreboard::s_add(root, sb_span);
		if ($urandom_range(0, 3) == 0) begin
			lo = hi; hi = brent_scoreboard::s_sub(root, sa);
		end
		if ($urandom_range(0, 19) == 0) begin
			lo = S_MIN; hi = S_MAX;
		end
		slope = 64'($urandom_range(1, 1 << 20)) << $urandom_range(4, 24);
		if ($urandom_range(0, 1)) slope = -slope;
		case ($urandom_range(0, 9))
			0: tol = 33'h1_0000_0000;
			1: tol = {1'($urandom), $urandom};
			default: tol = 33'($urandom_range(1, 1000));
		endcase
		case ($urandom_range(0, 9))
			0: mx = 8'd255;
			1: mx = 8'($urandom_range(1, 5));
			default: mx = 8'($urandom_range(20, 100));
		endcase
		set_config(lo, hi, tol, mx);
	endtask

	// stimulus
	initial begin
		search_res_t r;
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0; paddr <= '0; pwdata <= '0;
		in_ch.valid <= 1'b0; in_ch.f_value <= '0;
		root = 0; slope = 64'sh1_0000_0000;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// widest bracket, zero tolerance, zero limit: stop at the high end
		set_config(S_MIN, S_MAX, 33'd0, 8'd0);
		send_value(S_MAX, r);
		send_value(S_MIN, r);
		// coarsest tolerance ends on the first step
		set_config(64'sd0, 64'sh1_0000_0000, 33'h1_0000_0000, 8'd255);
		send_value(-64'sd1, r);
		send_value(64'sd1, r);
		// same sign at both ends: not bracketed
		send_value(64'sd3, r);
		send_value(64'sd7, r);
		// exact zero at the low end
		send_value(64'sd0, r);
		send_value(64'sd5, r);
		// short limit fed with extreme values
		set_config(-64'sh2_0000_0000, 64'sh4_0000_0000, 33'd1, 8'd3);
		send_value(S_MIN, r);
		send_value(S_MAX, r);
		send_value(S_MAX, r);
		send_value(S_MIN, r);
		send_value(64'sd12345, r);
		send_value(64'sd0, r);
		// zero tolerance on a real slope
		root = 64'sh0_8000_0000;
		slope = -64'sh3_0000_0000;
		set_config(64'sd0, 64'sh1_0000_0000, 33'd0, 8'd40);
		run_search(0);

		while (items_sent < N_ITEMS) begin
			if (searches % 3 == 0 || $urandom_range(0, 1)) random_config();
			case ($urandom_range(0, 9))
				0: run_search(3);
				1, 2: run_search(2);
				3, 4, 5: run_search(1);
				default: run_search(0);
			endcase
		end
		in_ch.valid <= 1'b0;

		while (sb.pending() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		$display("%0d function values fed over %0d searches, %0d results checked",
			items_sent, searches, sb.checked);
		$display("final status counts: root %0d, unbracketed %0d, limit %0d",
			sb.ends[ST_ROOT], sb.ends[ST_NOBR], sb.ends[ST_LIMIT]);
		if (sb.fails == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

	// result side: random back-pressure and one long hold-off to fill the block
	initial begin
		int stall;
		int hold;
		bit held;
		bit calm;
		stall = 0; hold = 0; held = 0; calm = 0;
		out_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (out_ch.valid && out_ch.ready)
				sb.check_result(out_ch.point, out_ch.status, out_ch.done_res);
			if ($urandom_range(0, 99) < 2) calm = ~calm;
			if (!held && sb.checked >= 150) begin
				held = 1;
				hold = 600;
			end
			if (hold > 0) begin
				hold--;
				out_ch.ready <= 1'b0;
			end else if (stall > 0) begin
				stall--;
				out_ch.ready <= 1'b0;
			end else if (!calm && $urandom_range(0, 3) == 0) begin
				stall = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 120)
					: $urandom_range(1, 3);
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= 1'b1;
			end
		end
	end

endmodule

/* files.f */
design/brf_pkg.sv
design/brf_if.sv
design/brf_cfg.sv
design/brf_muldiv.sv
design/brent_root_finder.sv
bench/testbench.sv
